// ----- sv/dfhe_pkg.sv -----
// Shared types, command codes and fixed-code tables for the DEFLATE fixed Huffman encoder.
// No dependencies; every other file uses these by scoped names.
`default_nettype none

package dfhe_pkg;

  // Command codes
  localparam logic [1:0] CMD_LITERAL = 2'd0;
  localparam logic [1:0] CMD_EOB     = 2'd1;
  localparam logic [1:0] CMD_MATCH   = 2'd2;

  // Fixed literal/length code constants
  localparam logic [8:0] LIT_LOW_BASE   = 9'd48;
  localparam logic [8:0] LIT_HIGH_BASE  = 9'd400;
  localparam logic [8:0] LIT_SPLIT      = 9'd144;
  localparam logic [8:0] LEN8_BASE      = 9'd192;
  localparam logic [8:0] LEN8_FIRST_SYM = 9'd280;
  localparam logic [8:0] EOB_SYM        = 9'd256;
  localparam logic [8:0] FIRST_LEN_SYM  = 9'd257;
  localparam logic [8:0] LAST_LEN_SYM   = 9'd285;

  // Legal match operand limits
  localparam logic [8:0]  LEN_MIN  = 9'd3;
  localparam logic [8:0]  LEN_MAX  = LAST_LEN_SYM - 9'd27;
  localparam logic [15:0] DIST_MIN = 16'd1;
  localparam logic [15:0] DIST_MAX = 16'd32768;

  localparam int LEN_CODES  = 29;
  localparam int DIST_CODES = 30;

  // Classified beat leaving the first stage
  typedef struct packed {
    logic [1:0]  command;
    logic        err;
    logic [7:0]  lit;
    logic [8:0]  len;
    logic [15:0] distance;
    logic [LEN_CODES-2:0]  len_ge;   // bit i: length at or above base of code i+1
    logic [DIST_CODES-2:0] dist_ge;  // bit i: distance at or above base of code i+1
  } cls_t;

  // Code fields leaving the second stage, each already in send order
  typedef struct packed {
    logic        err;
    logic [8:0]  sym_rev;
    logic [3:0]  sym_len;
    logic [4:0]  len_x;
    logic [2:0]  len_xn;
    logic        has_dist;
    logic [4:0]  dist_rev;
    logic [12:0] dist_x;
    logic [3:0]  dist_xn;
  } fld_t;

  function automatic logic [8:0] len_base(input logic [4:0] idx);
    logic [8:0] b;
    case (idx)
      5'd0:  b = 9'd3;    5'd1:  b = 9'd4;    5'd2:  b = 9'd5;    5'd3:  b = 9'd6;
      5'd4:  b = 9'd7;    5'd5:  b = 9'd8;    5'd6:  b = 9'd9;    5'd7:  b = 9'd10;
      5'd8:  b = 9'd11;   5'd9:  b = 9'd13;   5'd10: b = 9'd15;   5'd11: b = 9'd17;
      5'd12: b = 9'd19;   5'd13: b = 9'd23;   5'd14: b = 9'd27;   5'd15: b = 9'd31;
      5'd16: b = 9'd35;   5'd17: b = 9'd43;   5'd18: b = 9'd51;   5'd19: b = 9'd59;
      5'd20: b = 9'd67;   5'd21: b = 9'd83;   5'd22: b = 9'd99;   5'd23: b = 9'd115;
      5'd24: b = 9'd131;  5'd25: b = 9'd163;  5'd26: b = 9'd195;  5'd27: b = 9'd227;
      5'd28: b = 9'd258;
      default: b = 9'd258;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] len_extra(input logic [4:0] idx);
    logic [2:0] e;
    if (idx < 5'd8 || idx > 5'd27) begin
      e = 3'd0;
    end else begin
      e = 3'(({1'b0, idx} - 6'd4) >> 2);
    end
    return e;
  endfunction

  function automatic logic [15:0] dist_base(input logic [4:0] idx);
    logic [15:0] b;
    case (idx)
      5'd0:  b = 16'd1;     5'd1:  b = 16'd2;     5'd2:  b = 16'd3;     5'd3:  b = 16'd4;
      5'd4:  b = 16'd5;     5'd5:  b = 16'd7;     5'd6:  b = 16'd9;     5'd7:  b = 16'd13;
      5'd8:  b = 16'd17;    5'd9:  b = 16'd25;    5'd10: b = 16'd33;    5'd11: b = 16'd49;
      5'd12: b = 16'd65;    5'd13: b = 16'd97;    5'd14: b = 16'd129;   5'd15: b = 16'd193;
      5'd16: b = 16'd257;   5'd17: b = 16'd385;   5'd18: b = 16'd513;   5'd19: b = 16'd769;
      5'd20: b = 16'd1025;  5'd21: b = 16'd1537;  5'd22: b = 16'd2049;  5'd23: b = 16'd3073;
      5'd24: b = 16'd4097;  5'd25: b = 16'd6145;  5'd26: b = 16'd8193;  5'd27: b = 16'd12289;
      5'd28: b = 16'd16385; 5'd29: b = 16'd24577;
      default: b = 16'd24577;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] dist_extra(input logic [4:0] idx);
    logic [3:0] e;
    if (idx < 5'd4) begin
      e = 4'd0;
    end else begin
      e = 4'((idx - 5'd2) >> 1);
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dfhe_classify.sv -----
// First stage: range check and base-table compares for the match operands.
// Uses dfhe_pkg for command codes, limits, base tables and the cls_t beat.
`default_nettype none

module dfhe_classify (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         command,
  input  wire logic [7:0]         literal_value,
  input  wire logic [8:0]         match_length,
  input  wire logic [15:0]        match_distance,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dfhe_pkg::cls_t          out_data
);

  dfhe_pkg::cls_t cls_next;
  logic           valid;
  dfhe_pkg::cls_t data;

  // Compare each operand against every base above the first in parallel
  always_comb begin
    logic len_ok;
    logic dist_ok;
    len_ok  = (match_length >= dfhe_pkg::LEN_MIN) && (match_length <= dfhe_pkg::LEN_MAX);
    dist_ok = (match_distance >= dfhe_pkg::DIST_MIN) &&
              (match_distance <= dfhe_pkg::DIST_MAX);
    cls_next.command  = command;
    cls_next.err      = (command == dfhe_pkg::CMD_MATCH) && !(len_ok && dist_ok);
    cls_next.lit      = literal_value;
    cls_next.len      = match_length;
    cls_next.distance = match_distance;
    for (int i = 0; i < dfhe_pkg::LEN_CODES - 1; i++) begin
      cls_next.len_ge[i] = match_length >= dfhe_pkg::len_base(5'(i + 1));
    end
    for (int i = 0; i < dfhe_pkg::DIST_CODES - 1; i++) begin
      cls_next.dist_ge[i] = match_distance >= dfhe_pkg::dist_base(5'(i + 1));
    end
  end

  // Advance when the stage is empty or its beat moves on
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= cls_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

// ----- sv/dfhe_code.sv -----
// Second stage: code indexes, extra-bit values and bit-reversed Huffman codes.
// Uses dfhe_pkg for tables, constants and the cls_t and fld_t beats.
`default_nettype none

module dfhe_code (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dfhe_pkg::cls_t     in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dfhe_pkg::fld_t          out_data
);

  dfhe_pkg::fld_t fld_next;
  logic           valid;
  dfhe_pkg::fld_t data;

  function automatic logic [8:0] rev9(input logic [8:0] v);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) begin
      r[i] = v[8 - i];
    end
    return r;
  endfunction

  function automatic logic [4:0] rev5(input logic [4:0] v);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) begin
      r[i] = v[4 - i];
    end
    return r;
  endfunction

  // Turn compares into indexes, then form every field in send order
  always_comb begin
    logic [4:0] li;
    logic [4:0] di;
    logic [8:0] sym;
    logic [8:0] code;
    logic [3:0] clen;
    li = 5'd0;
    for (int i = 0; i < dfhe_pkg::LEN_CODES - 1; i++) begin
      if (in_data.len_ge[i]) li = 5'(i + 1);
    end
    di = 5'd0;
    for (int i = 0; i < dfhe_pkg::DIST_CODES - 1; i++) begin
      if (in_data.dist_ge[i]) di = 5'(i + 1);
    end
    sym  = dfhe_pkg::FIRST_LEN_SYM + {4'd0, li};
    code = 9'd0;
    clen = 4'd0;
    fld_next.len_x    = 5'd0;
    fld_next.len_xn   = 3'd0;
    fld_next.has_dist = 1'b0;
    fld_next.dist_rev = rev5(di);
    fld_next.dist_x   = 13'(in_data.distance - dfhe_pkg::dist_base(di));
    fld_next.dist_xn  = dfhe_pkg::dist_extra(di);
    case (in_data.command)
      dfhe_pkg::CMD_LITERAL: begin
        if ({1'b0, in_data.lit} < dfhe_pkg::LIT_SPLIT) begin
          code = {1'b0, in_data.lit} + dfhe_pkg::LIT_LOW_BASE;
          clen = 4'd8;
        end else begin
          code = {1'b0, in_data.lit} - dfhe_pkg::LIT_SPLIT + dfhe_pkg::LIT_HIGH_BASE;
          clen = 4'd9;
        end
      end
      dfhe_pkg::CMD_EOB: begin
        code = dfhe_pkg::EOB_SYM - dfhe_pkg::EOB_SYM;
        clen = 4'd7;
      end
      dfhe_pkg::CMD_MATCH: begin
        if (!in_data.err) begin
          if (sym < dfhe_pkg::LEN8_FIRST_SYM) begin
            code = sym - dfhe_pkg::EOB_SYM;
            clen = 4'd7;
          end else begin
            code = sym - dfhe_pkg::LEN8_FIRST_SYM + dfhe_pkg::LEN8_BASE;
            clen = 4'd8;
          end
          fld_next.len_x    = 5'(in_data.len - dfhe_pkg::len_base(li));
          fld_next.len_xn   = dfhe_pkg::len_extra(li);
          fld_next.has_dist = 1'b1;
        end
      end
      default: begin
        code = 9'd0;
        clen = 4'd0;
      end
    endcase
    fld_next.err     = in_data.err;
    fld_next.sym_rev = rev9(code) >> (4'd9 - clen);
    fld_next.sym_len = clen;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= fld_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

// ----- sv/dfhe_pack.sv -----
// Third stage: pack the fields into one send-order word and hold it as the output register.
// Uses dfhe_pkg for the fld_t beat.
`default_nettype none

module dfhe_pack (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dfhe_pkg::fld_t     in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [30:0]             code_bits,
  output logic [4:0]              bit_count,
  output logic                    range_error
);

  logic [30:0] bits_next;
  logic [4:0]  count_next;
  logic        valid;
  logic [30:0] bits;
  logic [4:0]  count;
  logic        err;

  // Place each field after the ones sent before it
  always_comb begin
    logic [4:0] o1;
    logic [4:0] o2;
    o1 = {1'b0, in_data.sym_len} + {2'b0, in_data.len_xn};
    o2 = o1 + 5'd5;
    bits_next = 31'(in_data.sym_rev) | (31'(in_data.len_x) << in_data.sym_len);
    count_next = o1;
    if (in_data.has_dist) begin
      bits_next  = bits_next | (31'(in_data.dist_rev) << o1) | (31'(in_data.dist_x) << o2);
      count_next = o2 + {1'b0, in_data.dist_xn};
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bits  <= bits_next;
      count <= count_next;
      err   <= in_data.err;
    end
  end

  assign out_valid   = valid;
  assign code_bits   = bits;
  assign bit_count   = count;
  assign range_error = err;

endmodule

`default_nettype wire

// ----- sv/deflate_fixed_huffman_symbol_encoder.sv -----
// Top level of the DEFLATE fixed Huffman symbol encoder: three-stage pipeline.
// Uses dfhe_pkg, dfhe_classify, dfhe_code and dfhe_pack.
//
//   channel  handshake              payload
//   -------  ---------------------  ------------------------------------------------
//   symbol   sym_valid / sym_stall  command, literal_value, match_length, match_distance
//   code     code_valid/code_stall  code_bits, bit_count, range_error
//
// Each beat passes through compare, code forming and packing into the output
// register. While sym_stall is low, a new beat may enter every cycle (one per cycle).
// sym_stall rises only when every stage holds a beat and code_stall is high; empty
// stages close up behind a stalled output. rst (synchronous) empties all stages.
`default_nettype none

module deflate_fixed_huffman_symbol_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sym_valid,
  output logic             sym_stall,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  literal_value,
  input  wire logic [8:0]  match_length,
  input  wire logic [15:0] match_distance,
  output logic             code_valid,
  input  wire logic        code_stall,
  output logic [30:0]      code_bits,
  output logic [4:0]       bit_count,
  output logic             range_error
);

  logic           s1_ready;
  logic           s1_valid;
  dfhe_pkg::cls_t s1_data;
  logic           s2_ready;
  logic           s2_valid;
  dfhe_pkg::fld_t s2_data;
  logic           s3_ready;

  dfhe_classify u_classify (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (sym_valid),
    .in_ready       (s1_ready),
    .command        (command),
    .literal_value  (literal_value),
    .match_length   (match_length),
    .match_distance (match_distance),
    .out_valid      (s1_valid),
    .out_ready      (s2_ready),
    .out_data       (s1_data)
  );

  dfhe_code u_code (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s2_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s3_ready),
    .out_data  (s2_data)
  );

  dfhe_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s2_valid),
    .in_ready    (s3_ready),
    .in_data     (s2_data),
    .out_valid   (code_valid),
    .out_ready   (!code_stall),
    .code_bits   (code_bits),
    .bit_count   (bit_count),
    .range_error (range_error)
  );

  // Hold the input side only when the whole pipe is full and blocked
  assign sym_stall = !s1_ready;

`ifndef SYNTHESIS
  // An error beat carries no bits
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    code_valid && range_error |-> code_bits == 31'd0 && bit_count == 5'd0)
    else $error("range error beat carries code bits");

  // Any symbol sent is at least seven bits long
  a_min_len: assert property (@(posedge clk) disable iff (rst)
    code_valid && bit_count != 5'd0 |-> bit_count >= 5'd7)
    else $error("bit count below shortest symbol");

  // Bits at and above the count stay clear
  a_clean_top: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> (code_bits >> bit_count) == 31'd0)
    else $error("code bits set beyond bit count");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !code_valid && !s1_valid && !s2_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
